// ----- design/slid_pkg.sv -----
package slid_pkg;

	// default list depth
	localparam int CAPACITY_DEF = 8;

	// fixed field widths
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 3;
	localparam int CNT_W    = 4;

	// request opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// one result as it sits in the output buffer
	typedef struct packed {
		status_t             status;
		logic [POS_W-1:0]    position;
		logic [CNT_W-1:0]    entry_count;
	} result_t;

	// update command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

// ----- design/slid_cell.sv -----
module slid_cell
	import slid_pkg::*;
(
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] item,
	input  logic                    occupied,
	input  logic                    lt_left,
	input  logic signed [VAL_W-1:0] left_val,
	input  logic signed [VAL_W-1:0] right_val,
	output logic                    lt,
	output logic                    eq,
	output logic signed [VAL_W-1:0] value
);

	logic signed [VAL_W-1:0] value_q;

	// local compare against the broadcast value
	assign lt    = occupied && (value_q < item);
	assign eq    = occupied && (value_q == item);
	assign value = value_q;

	// insert: cells at or past the insertion point take the item or shift up
	// remove: cells at or past the removal point take their right neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			value_q <= lt_left ? item : left_val;
		end else if (ctl.rem && !lt) begin
			value_q <= right_val;
		end
	end

endmodule

// ----- design/slid_rbuf.sv -----
module slid_rbuf
	import slid_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	result_t head_q;
	result_t spare_q;
	logic    head_vld_q;
	logic    spare_vld_q;
	logic    pop;

	assign pop       = head_vld_q && !out_stall;
	assign full      = spare_vld_q;
	assign out_valid = head_vld_q;
	assign out_data  = head_q;

	// occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (pop) begin
			head_vld_q  <= spare_vld_q || push;
			spare_vld_q <= 1'b0;
		end else if (push) begin
			if (head_vld_q) begin
				spare_vld_q <= 1'b1;
			end else begin
				head_vld_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= spare_vld_q ? spare_q : push_data;
		end else if (push) begin
			if (head_vld_q) begin
				spare_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

endmodule

// ----- design/sorted_list_insert_delete.sv -----
// sorted list of signed values kept in a row of compare-and-shift cells
// each result is registered into a two-entry result buffer when its request is taken
// throughput: one request per cycle while req_stall is low; every cell compares and shifts at once
// a two-entry result buffer lets one result wait while the next request is taken
// reset clears the entry count and the result buffer; cell values are not cleared
module sorted_list_insert_delete
	import slid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     opcode,
	input  logic signed [VAL_W-1:0]  item_value,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [POS_W-1:0]         position,
	output logic [CNT_W-1:0]         entry_count
);

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTI_W = $clog2(CAPACITY + 1);

	logic [CNTI_W-1:0]       count_q;
	logic [CNTI_W-1:0]       count_nxt;
	logic                    accept;
	logic                    is_full;
	logic                    is_empty;
	logic                    found;
	logic [CAPACITY-1:0]     lt_vec;
	logic [CAPACITY-1:0]     eq_vec;
	logic [CAPACITY-1:0]     bnd_vec;
	logic [CAPACITY-1:0]     lt_left_vec;
	logic [CAPACITY-1:0]     occ_vec;
	logic signed [VAL_W-1:0] cell_val [CAPACITY];
	logic [IDX_W-1:0]        pos_idx;
	cell_ctl_t               ctl;
	result_t                 res_d;
	result_t                 res_out;
	logic                    buf_full;

	assign req_stall = buf_full;
	assign accept    = req_valid && !req_stall;
	assign is_full   = (count_q == CNTI_W'(CAPACITY));
	assign is_empty  = (count_q == '0);

	// occupancy flags
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ_vec[i] = (CNTI_W'(i) < count_q);
		end
	end

	// neighbor compare flags
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_left_vec[i] = (i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1];
			bnd_vec[i]     = !lt_vec[i] && lt_left_vec[i];
		end
	end

	// position of the first entry not less than the item
	always_comb begin
		pos_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (bnd_vec[i]) begin
				pos_idx = pos_idx | IDX_W'(i);
			end
		end
	end

	assign found   = |(eq_vec & bnd_vec);
	assign ctl.ins = accept && (opcode == OP_INSERT) && !is_full;
	assign ctl.rem = accept && (opcode == OP_REMOVE) && found;

	// cell row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;

		if (g == 0) begin : g_first
			assign left_v = item_value;
		end else begin : g_mid
			assign left_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[g];
		end else begin : g_inner
			assign right_v = cell_val[g+1];
		end

		slid_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.item      (item_value),
			.occupied  (occ_vec[g]),
			.lt_left   (lt_left_vec[g]),
			.left_val  (left_v),
			.right_val (right_v),
			.lt        (lt_vec[g]),
			.eq        (eq_vec[g]),
			.value     (cell_val[g])
		);
	end

	// status and next count
	always_comb begin
		count_nxt       = count_q;
		res_d.status    = ST_DONE;
		res_d.position  = POS_W'(pos_idx);
		if (opcode == OP_INSERT) begin
			if (is_full) begin
				res_d.status   = ST_FULL;
				res_d.position = '0;
			end else begin
				count_nxt = count_q + CNTI_W'(1);
			end
		end else if (is_empty) begin
			res_d.status   = ST_EMPTY;
			res_d.position = '0;
		end else if (!found) begin
			res_d.status   = ST_MISSING;
			res_d.position = '0;
		end else begin
			count_nxt = count_q - CNTI_W'(1);
		end
		res_d.entry_count = CNT_W'(count_nxt);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	slid_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_d),
		.full      (buf_full),
		.out_valid (res_valid),
		.out_stall (res_stall),
		.out_data  (res_out)
	);

	assign status      = res_out.status;
	assign position    = res_out.position;
	assign entry_count = res_out.entry_count;

`ifndef SYNTHESIS
	// count stays within the list depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTI_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// held entries stay sorted: the less-than flags form a prefix
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(lt_vec & (lt_vec + CAPACITY'(1))) == '0)
		else $error("less-than flags not a prefix");

	// an insert into a list with room grows it by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (opcode == OP_INSERT) && !is_full
		|=> count_q == $past(count_q) + CNTI_W'(1))
		else $error("insert did not grow the list");

	// requests are held back only while a result is waiting
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid)
		else $error("request stalled with no result pending");
`endif

endmodule

// ----- sim/tb_sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;
	import slid_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 80;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic                    opcode;
	logic signed [VAL_W-1:0] item_value;
	logic                    res_valid;
	logic                    res_stall;
	logic [STATUS_W-1:0]     status;
	logic [POS_W-1:0]        position;
	logic [CNT_W-1:0]        entry_count;

	// predicted list contents and results still owed by the block
	logic signed [VAL_W-1:0] held_values[$];
	result_t                 pending_results[$];

	int          error_count  = 0;
	int          cycle_count  = 0;
	int          burst_left   = 0;
	bit          gaps_on      = 1'b0;
	bit          hold_request = 1'b0;
	stall_mode_t stall_mode   = STALL_NONE;

	sorted_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.item_value (item_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.position   (position),
		.entry_count(entry_count)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sorted_list_insert_delete: errors");
			$finish;
		end
	end

	// apply one request to the predicted list and return its result
	function automatic result_t predict_list_update(input logic op,
			input logic signed [VAL_W-1:0] val);
		result_t r;
		int      idx;
		r.status   = ST_DONE;
		r.position = '0;
		idx        = 0;
		if (op == OP_INSERT) begin
			if (held_values.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// goes in front of the first entry not less than it
				while (idx < held_values.size() && held_values[idx] < val)
					idx++;
				held_values.insert(idx, val);
				r.position = POS_W'(idx);
			end
		end else if (held_values.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			while (idx < held_values.size() && held_values[idx] != val)
				idx++;
			if (idx == held_values.size()) begin
				r.status = ST_MISSING;
			end else begin
				held_values.delete(idx);
				r.position = POS_W'(idx);
			end
		end
		r.entry_count = CNT_W'(held_values.size());
		return r;
	endfunction

	// random value, biased toward held entries and a small cluster of duplicates
	function automatic logic signed [VAL_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4 && held_values.size() > 0)
			return held_values[$urandom_range(0, held_values.size() - 1)];
		if (sel < 7)
			return int'($urandom_range(0, 8)) - 4;
		if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return -1;
				default: return 0;
			endcase
		end
		return $urandom();
	endfunction

	// offer one request, with bursts and gaps, and predict it once taken
	task automatic send_request(input logic op, input logic signed [VAL_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid  <= 1'b1;
		opcode     <= op;
		item_value <= val;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(predict_list_update(op, val));
	endtask

	// result stall: pattern per phase, plus a long hold-off on demand
	initial begin
		int hold_left;
		int beat;
		hold_left = 0;
		beat      = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			beat++;
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE:   res_stall <= 1'b0;
					STALL_RANDOM: res_stall <= ($urandom_range(0, 2) == 0);
					default:      res_stall <= ((beat % 7) < 3);
				endcase
			end
		end
	end

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d position %0d count %0d",
					status, position, entry_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					error_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					error_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, entry_count);
					error_count++;
				end
			end
		end
	end

	// remove from empty, extremes at both ends, absent value
	task automatic test_empty_list();
		send_request(OP_REMOVE, 0);
		send_request(OP_INSERT, 32'sh7fff_ffff);
		send_request(OP_INSERT, 32'sh8000_0000);
		send_request(OP_REMOVE, 5);
		send_request(OP_REMOVE, 32'sh7fff_ffff);
		send_request(OP_REMOVE, 32'sh8000_0000);
		send_request(OP_REMOVE, -1);
	endtask

	// fill with duplicates and extremes, overflow, then remove first of equals
	task automatic test_full_list();
		send_request(OP_INSERT, 5);
		send_request(OP_INSERT, -1);
		send_request(OP_INSERT, 0);
		send_request(OP_INSERT, 5);
		send_request(OP_INSERT, 32'sh8000_0000);
		send_request(OP_INSERT, 32'sh7fff_ffff);
		send_request(OP_INSERT, 0);
		send_request(OP_INSERT, 32'sh5555_5555);
		send_request(OP_INSERT, 1);
		send_request(OP_REMOVE, 5);
		send_request(OP_REMOVE, 0);
		send_request(OP_REMOVE, 42);
		send_request(OP_REMOVE, 32'sh7fff_ffff);
	endtask

	// random inserts and removes; the insert share drifts so the list
	// swings between empty and full
	task automatic test_random_traffic(input int n, input bit gaps,
			input stall_mode_t smode);
		int insert_pct;
		logic op;
		gaps_on    = gaps;
		stall_mode = smode;
		insert_pct = 50;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 25;
					1: insert_pct = 50;
					default: insert_pct = 75;
				endcase
			end
			op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			send_request(op, pick_value());
		end
	endtask

	// receiver holds off long enough for the block to fill and stall requests
	task automatic test_result_backpressure();
		gaps_on      = 1'b0;
		stall_mode   = STALL_NONE;
		hold_request = 1'b1;
		for (int k = 0; k < 40; k++)
			send_request(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_REMOVE,
				pick_value());
	endtask

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		opcode     = OP_INSERT;
		item_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_full_list();
		test_random_traffic(300, 1'b0, STALL_NONE);
		test_random_traffic(500, 1'b1, STALL_RANDOM);
		test_result_backpressure();
		test_random_traffic(400, 1'b1, STALL_PATTERN);
		test_random_traffic(450, 1'b1, STALL_RANDOM);

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (error_count == 0)
			$display("tb_sorted_list_insert_delete: clean");
		else
			$display("tb_sorted_list_insert_delete: errors");
		$finish;
	end

endmodule
